### rtl/core/gb_pkg.sv
package gb_pkg;

   // store sizes
   localparam int GLYPH_BYTES     = 4096;
   localparam int FRAME_BYTES     = 1024;
   localparam int DESC_DEPTH      = 256;
   localparam int MAX_GLYPH_WIDTH = 32;
   localparam int MAX_ROWS        = 32;
   localparam int GLYPH_AW        = $clog2(GLYPH_BYTES);
   localparam int FRAME_AW        = $clog2(FRAME_BYTES);
   localparam int DESC_AW         = $clog2(DESC_DEPTH);
   localparam int DESC_W          = 18;
   // frame address arithmetic before the bound check
   localparam int FCALC_W         = 14;
   localparam int GCALC_W         = GLYPH_AW + 1;

   localparam logic [7:0] SPACE_CODE = 8'd32;

   // commands
   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_GLYPH = 3'd1;
   localparam logic [2:0] CMD_DESC  = 3'd2;
   localparam logic [2:0] CMD_DRAW  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // register indexes
   localparam logic [2:0] REG_FIRST_CHAR   = 3'd0;
   localparam logic [2:0] REG_LAST_CHAR    = 3'd1;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
   localparam logic [2:0] REG_CHAR_GAP     = 3'd3;
   localparam logic [2:0] REG_LAYOUT       = 3'd4;
   localparam logic [2:0] REG_LINE_STRIDE  = 3'd5;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] last_char;
      logic [5:0] glyph_height;
      logic [3:0] char_gap;
      logic       layout;
      logic [7:0] line_stride;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR,
      S_LOAD,
      S_RD,
      S_RDW,
      S_DESC,
      S_DSET,
      S_GRD,
      S_GWT,
      S_FRD,
      S_FWR,
      S_CUR,
      S_DONE
   } state_type;

endpackage

### rtl/core/gb_ifs.sv
interface gb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [11:0] addr;
   logic [7:0]  byte_data;
   logic [5:0]  glyph_width;
   logic [11:0] glyph_offset;
   logic [7:0]  char_code;
   modport source (output valid, cmd, addr, byte_data, glyph_width, glyph_offset, char_code,
                   input ready);
   modport sink (input valid, cmd, addr, byte_data, glyph_width, glyph_offset, char_code,
                 output ready);
endinterface

interface gb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic [9:0] cursor_pos;
   modport source (output valid, read_byte, cursor_pos, input ready);
   modport sink (input valid, read_byte, cursor_pos, output ready);
endinterface

interface gb_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/gb_ram.sv
module gb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### rtl/core/gb_csr.sv
module gb_csr (
   input  logic            clock,
   input  logic            reset,
   gb_csr_if.sink          csr_bus,
   output gb_pkg::cfg_type cfg
);

   gb_pkg::cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_char   <= 8'd32;
         cfg_ff.last_char    <= 8'd126;
         cfg_ff.glyph_height <= 6'd8;
         cfg_ff.char_gap     <= 4'd1;
         cfg_ff.layout       <= 1'b0;
         cfg_ff.line_stride  <= 8'd16;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            gb_pkg::REG_FIRST_CHAR:   cfg_ff.first_char   <= csr_bus.data;
            gb_pkg::REG_LAST_CHAR:    cfg_ff.last_char    <= csr_bus.data;
            gb_pkg::REG_GLYPH_HEIGHT: cfg_ff.glyph_height <= csr_bus.data[5:0];
            gb_pkg::REG_CHAR_GAP:     cfg_ff.char_gap     <= csr_bus.data[3:0];
            gb_pkg::REG_LAYOUT:       cfg_ff.layout       <= csr_bus.data[0];
            gb_pkg::REG_LINE_STRIDE:  cfg_ff.line_stride  <= csr_bus.data;
            default: ;
         endcase
      end
   end

endmodule

### rtl/core/gb_ctrl.sv
module gb_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  gb_pkg::cfg_type cfg,
   gb_req_if.sink          req_bus,
   gb_rsp_if.source        rsp_bus
);

   localparam int FAW = gb_pkg::FRAME_AW;
   localparam int GAW = gb_pkg::GLYPH_AW;
   localparam int DAW = gb_pkg::DESC_AW;
   localparam int CW  = gb_pkg::FCALC_W;
   localparam int GCW = gb_pkg::GCALC_W;

   gb_pkg::state_type state_ff, state_in;

   // latched item
   logic [2:0]  cmd_ff;
   logic [11:0] addr_ff;
   logic [7:0]  data_ff;
   logic [5:0]  gw_ff;
   logic [11:0] goff_ff;
   logic [7:0]  code_ff;

   // sequencer registers
   logic [FAW-1:0] clr_ff, clr_in;
   logic           pend_ff, pend_in;
   logic [9:0]     cursor_ff, cursor_in;
   logic [7:0]     rdv_ff, rdv_in;
   logic [5:0]     w_ff, w_in;
   logic [2:0]     nb_ff, nb_in;
   logic [5:0]     rows_ff, rows_in;
   logic [5:0]     row_ff, row_in;
   logic [1:0]     k_ff, k_in;
   logic [2:0]     sub_ff, sub_in;
   logic [GCW-1:0] gaddr_ff, gaddr_in;
   logic [CW-1:0]  rbase_ff, rbase_in;
   logic [CW-1:0]  pbase_ff, pbase_in;
   logic [7:0]     g_ff, g_in;
   logic [FAW-1:0] faddr_ff, faddr_in;
   logic [7:0]     fval_ff, fval_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [9:0] rsp_cur_ff, rsp_cur_in;

   // memory ports
   logic             g_we, d_we, f_we;
   logic [GAW-1:0]   g_addr;
   logic [DAW-1:0]   d_addr;
   logic [FAW-1:0]   f_addr;
   logic [7:0]       g_rdata, f_rdata, f_wdata;
   logic [gb_pkg::DESC_W-1:0] d_rdata;

   // draw helpers
   logic [7:0]    code_eff, idx;
   logic [5:0]    w_cap, h_cap;
   logic [15:0]   shifted;
   logic [CW-1:0] fcalc;
   logic [4:0]    col;
   logic          need, last_sub, last_k, last_row;
   logic          accept;

   gb_ram #(.WIDTH(8), .DEPTH(gb_pkg::GLYPH_BYTES)) u_glyph (
      .clock(clock), .we(g_we), .addr(g_addr), .wdata(data_ff), .rdata(g_rdata));
   gb_ram #(.WIDTH(gb_pkg::DESC_W), .DEPTH(gb_pkg::DESC_DEPTH)) u_desc (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata({gw_ff, goff_ff}), .rdata(d_rdata));
   gb_ram #(.WIDTH(8), .DEPTH(gb_pkg::FRAME_BYTES)) u_frame (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == gb_pkg::S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_byte  = rsp_byte_ff;
   assign rsp_bus.cursor_pos = rsp_cur_ff;

   // descriptor index, out-of-font codes draw a space
   assign code_eff = (code_ff < cfg.first_char || code_ff > cfg.last_char)
                     ? gb_pkg::SPACE_CODE : code_ff;
   assign idx   = code_eff - cfg.first_char;
   assign w_cap = (d_rdata[17:12] > 6'(gb_pkg::MAX_GLYPH_WIDTH))
                  ? 6'(gb_pkg::MAX_GLYPH_WIDTH) : d_rdata[17:12];
   assign h_cap = (cfg.glyph_height > 6'(gb_pkg::MAX_ROWS))
                  ? 6'(gb_pkg::MAX_ROWS) : cfg.glyph_height;

   // frame target of the current sub-step
   assign shifted = {g_ff, 8'h00} >> cursor_ff[2:0];
   assign col     = {k_ff, sub_ff};
   always_comb begin
      if (!cfg.layout) begin
         fcalc = rbase_ff + CW'(cursor_ff[9:3]) + CW'(k_ff) + CW'(sub_ff[0]);
         need  = fcalc < CW'(gb_pkg::FRAME_BYTES);
      end else begin
         fcalc = pbase_ff + CW'(cursor_ff) + CW'(col);
         need  = ({1'b0, col} < w_ff) && g_ff[~sub_ff] && (fcalc < CW'(gb_pkg::FRAME_BYTES));
      end
   end
   assign last_sub = cfg.layout ? (sub_ff == 3'd7) : (sub_ff[0] || cursor_ff[2:0] == 3'd0);
   assign last_k   = ({1'b0, k_ff} == nb_ff - 3'd1);
   assign last_row = (row_ff == rows_ff - 6'd1);

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gb_pkg::S_CLR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_bus.cmd;
         addr_ff <= req_bus.addr;
         data_ff <= req_bus.byte_data;
         gw_ff   <= req_bus.glyph_width;
         goff_ff <= req_bus.glyph_offset;
         code_ff <= req_bus.char_code;
      end
      rdv_ff      <= rdv_in;
      w_ff        <= w_in;
      nb_ff       <= nb_in;
      rows_ff     <= rows_in;
      row_ff      <= row_in;
      k_ff        <= k_in;
      sub_ff      <= sub_in;
      gaddr_ff    <= gaddr_in;
      rbase_ff    <= rbase_in;
      pbase_ff    <= pbase_in;
      g_ff        <= g_in;
      faddr_ff    <= faddr_in;
      fval_ff     <= fval_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      cursor_in    = cursor_ff;
      rdv_in       = rdv_ff;
      w_in         = w_ff;
      nb_in        = nb_ff;
      rows_in      = rows_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      sub_in       = sub_ff;
      gaddr_in     = gaddr_ff;
      rbase_in     = rbase_ff;
      pbase_in     = pbase_ff;
      g_in         = g_ff;
      faddr_in     = faddr_ff;
      fval_in      = fval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cur_in   = rsp_cur_ff;
      g_we    = 1'b0;
      d_we    = 1'b0;
      f_we    = 1'b0;
      g_addr  = gaddr_ff[GAW-1:0];
      d_addr  = idx;
      f_addr  = fcalc[FAW-1:0];
      f_wdata = f_rdata | fval_ff;

      // result register drains independently
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         gb_pkg::S_IDLE: begin
            if (accept) begin
               case (req_bus.cmd)
                  gb_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     pend_in  = 1'b1;
                     state_in = gb_pkg::S_CLR;
                  end
                  gb_pkg::CMD_GLYPH, gb_pkg::CMD_DESC: state_in = gb_pkg::S_LOAD;
                  gb_pkg::CMD_DRAW: state_in = gb_pkg::S_DESC;
                  gb_pkg::CMD_READ: state_in = gb_pkg::S_RD;
                  default: state_in = gb_pkg::S_DONE;
               endcase
            end
         end
         // clearing pass, one byte a cycle
         gb_pkg::S_CLR: begin
            f_we    = 1'b1;
            f_addr  = clr_ff;
            f_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == FAW'(gb_pkg::FRAME_BYTES - 1)) begin
               cursor_in = '0;
               pend_in   = 1'b0;
               state_in  = pend_ff ? gb_pkg::S_DONE : gb_pkg::S_IDLE;
            end
         end
         gb_pkg::S_LOAD: begin
            g_addr = addr_ff[GAW-1:0];
            d_addr = addr_ff[DAW-1:0];
            g_we   = (cmd_ff == gb_pkg::CMD_GLYPH) &&
                     ({1'b0, addr_ff} < 13'(gb_pkg::GLYPH_BYTES));
            d_we   = (cmd_ff == gb_pkg::CMD_DESC) &&
                     ({1'b0, addr_ff} < 13'(gb_pkg::DESC_DEPTH));
            state_in = gb_pkg::S_DONE;
         end
         gb_pkg::S_RD: begin
            f_addr   = addr_ff[FAW-1:0];
            state_in = gb_pkg::S_RDW;
         end
         gb_pkg::S_RDW: begin
            rdv_in   = ({1'b0, addr_ff} < 13'(gb_pkg::FRAME_BYTES)) ? f_rdata : 8'h00;
            state_in = gb_pkg::S_DONE;
         end
         gb_pkg::S_DESC: begin
            state_in = gb_pkg::S_DSET;
         end
         // descriptor arrives, set up the row walk
         gb_pkg::S_DSET: begin
            w_in     = w_cap;
            nb_in    = 3'((w_cap + 6'd7) >> 3);
            rows_in  = h_cap;
            row_in   = '0;
            k_in     = '0;
            sub_in   = '0;
            gaddr_in = GCW'(d_rdata[11:0]);
            rbase_in = '0;
            pbase_in = '0;
            state_in = (h_cap == 6'd0 || w_cap == 6'd0) ? gb_pkg::S_CUR : gb_pkg::S_GRD;
         end
         gb_pkg::S_GRD: begin
            state_in = gb_pkg::S_GWT;
         end
         gb_pkg::S_GWT: begin
            g_in     = (gaddr_ff < GCW'(gb_pkg::GLYPH_BYTES)) ? g_rdata : 8'h00;
            state_in = gb_pkg::S_FRD;
         end
         gb_pkg::S_FRD, gb_pkg::S_FWR: begin
            if (state_ff == gb_pkg::S_FWR) begin
               f_we   = 1'b1;
               f_addr = faddr_ff;
            end
            if (state_ff == gb_pkg::S_FRD && need) begin
               // read the target byte, OR in next cycle
               faddr_in = fcalc[FAW-1:0];
               if (cfg.layout) begin
                  fval_in = 8'd1 << row_ff[2:0];
               end else begin
                  fval_in = sub_ff[0] ? shifted[7:0] : shifted[15:8];
               end
               state_in = gb_pkg::S_FWR;
            end else if (!last_sub) begin
               sub_in   = sub_ff + 3'd1;
               state_in = gb_pkg::S_FRD;
            end else begin
               // next glyph byte
               sub_in   = '0;
               gaddr_in = gaddr_ff + 1'b1;
               state_in = gb_pkg::S_GRD;
               if (last_k) begin
                  k_in     = '0;
                  row_in   = row_ff + 6'd1;
                  rbase_in = rbase_ff + CW'(cfg.line_stride);
                  if (row_ff[2:0] == 3'd7) begin
                     pbase_in = pbase_ff + CW'(cfg.line_stride);
                  end
                  if (last_row) begin
                     state_in = gb_pkg::S_CUR;
                  end
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         gb_pkg::S_CUR: begin
            cursor_in = cursor_ff + 10'(w_ff) + 10'(cfg.char_gap);
            state_in  = gb_pkg::S_DONE;
         end
         // hand the result to the output register
         gb_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = (cmd_ff == gb_pkg::CMD_READ) ? rdv_ff : 8'h00;
               rsp_cur_in   = cursor_ff;
               state_in     = gb_pkg::S_IDLE;
            end
         end
         default: state_in = gb_pkg::S_IDLE;
      endcase
   end

endmodule

### rtl/core/glyph_blitter_core.sv
// channel   dir  handshake     payload
// req_bus   in   valid/ready   cmd, addr, byte_data, glyph_width, glyph_offset, char_code
// rsp_bus   out  valid/ready   read_byte, cursor_pos
// csr_bus   in   valid/ready   index, data (always ready)
//
// a draw walks each row of the glyph byte by byte; every glyph byte covers one frame
// byte in aligned row-major, two in shifted row-major and one per column in page layout,
// and each frame byte that it sets is written by read-modify-write through the single
// port of the frame memory
// after reset a clearing pass runs before the first item is taken
// a result waiting in the output register does not stop the next transfer in; the
// sequencer holds in its last state until the output register is free
module glyph_blitter_core (
   input logic      clock,
   input logic      reset,
   gb_req_if.sink   req_bus,
   gb_rsp_if.source rsp_bus,
   gb_csr_if.sink   csr_bus
);

   gb_pkg::cfg_type cfg;

   gb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   gb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

### rtl/core/gb_checker.sv
module gb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte,
   input logic [9:0] rsp_cursor_pos
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_byte) && $stable(rsp_cursor_pos))
      else $error("result changed while stalled");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken during work");

   // clearing pass and empty output after reset
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

endmodule

bind glyph_blitter_core gb_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_read_byte  (rsp_bus.read_byte),
   .rsp_cursor_pos (rsp_bus.cursor_pos)
);

### dv/glyph_blitter_core_tb.sv
`timescale 1ns / 1ps

module glyph_blitter_core_tb;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 30;
   localparam int FONT_LO     = 128;
   localparam int FONT_HI     = gb_pkg::GLYPH_BYTES - 32;

   // commands the block leaves without effect
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [11:0] addr;
      logic [7:0]  byte_data;
      logic [5:0]  glyph_width;
      logic [11:0] glyph_offset;
      logic [7:0]  char_code;
   } blit_cmd_type;

   typedef struct {
      logic [7:0] read_byte;
      logic [9:0] cursor_pos;
   } blit_out_type;

   typedef struct {
      blit_cmd_type  item;
      bit            typed;
      blit_out_type  out;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gb_req_if req_bus();
   gb_rsp_if rsp_bus();
   gb_csr_if csr_bus();

   glyph_blitter_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow state of the blitter
   logic [7:0]  font_mem [gb_pkg::GLYPH_BYTES];
   bit          font_set [gb_pkg::GLYPH_BYTES];
   logic [5:0]  desc_w   [gb_pkg::DESC_DEPTH];
   logic [11:0] desc_off [gb_pkg::DESC_DEPTH];
   bit          desc_set [gb_pkg::DESC_DEPTH];
   logic [7:0]  fb       [gb_pkg::FRAME_BYTES];
   logic [9:0]  cur;
   gb_pkg::cfg_type cfg;

   blit_out_type pending_q[$];
   int           errors = 0;
   int           cycles = 0;
   bit           quiet_rsp = 1'b0;

   task automatic report(string what, int got, int want);
      $display("tb: mismatch %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int desc_index(logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c < cfg.first_char || c > cfg.last_char) c = gb_pkg::SPACE_CODE;
      return int'(8'(c - cfg.first_char));
   endfunction

   // a draw must only touch glyph bytes and descriptors that were loaded
   function automatic bit draw_ok(logic [7:0] code);
      int idx, w, nb, rows, a;
      idx = desc_index(code);
      if (!desc_set[idx]) return 1'b0;
      w = (desc_w[idx] > gb_pkg::MAX_GLYPH_WIDTH) ? gb_pkg::MAX_GLYPH_WIDTH : desc_w[idx];
      nb = (w + 7) / 8;
      rows = (cfg.glyph_height > gb_pkg::MAX_ROWS) ? gb_pkg::MAX_ROWS : cfg.glyph_height;
      for (int r = 0; r < rows; r++)
         for (int k = 0; k < nb; k++) begin
            a = desc_off[idx] + r * nb + k;
            if (a < gb_pkg::GLYPH_BYTES && !font_set[a]) return 1'b0;
         end
      return 1'b1;
   endfunction

   function automatic void fb_or(int a, logic [7:0] v);
      if (a < gb_pkg::FRAME_BYTES) fb[a] = fb[a] | v;
   endfunction

   // render one character into the shadow frame
   function automatic void render_char(logic [7:0] code);
      int idx, w, nb, rows, a, sh, x, col;
      logic [7:0] g;
      idx = desc_index(code);
      w = (desc_w[idx] > gb_pkg::MAX_GLYPH_WIDTH) ? gb_pkg::MAX_GLYPH_WIDTH : desc_w[idx];
      nb = (w + 7) / 8;
      rows = (cfg.glyph_height > gb_pkg::MAX_ROWS) ? gb_pkg::MAX_ROWS : cfg.glyph_height;
      x = cur;
      sh = x % 8;
      for (int r = 0; r < rows; r++)
         for (int k = 0; k < nb; k++) begin
            a = desc_off[idx] + r * nb + k;
            g = (a < gb_pkg::GLYPH_BYTES) ? font_mem[a] : 8'h00;
            if (!cfg.layout) begin
               a = r * cfg.line_stride + x / 8 + k;
               fb_or(a, g >> sh);
               if (sh != 0) fb_or(a + 1, 8'(g << (8 - sh)));
            end else begin
               a = (r / 8) * cfg.line_stride + x;
               for (int b = 0; b < 8; b++) begin
                  col = k * 8 + b;
                  if (col < w && g[7 - b]) fb_or(a + col, 8'(1 << (r % 8)));
               end
            end
         end
      cur = 10'(cur + w + cfg.char_gap);
   endfunction

   function automatic blit_out_type blit_predict(blit_cmd_type it);
      blit_out_type o;
      o.read_byte = 8'h00;
      case (it.cmd)
         gb_pkg::CMD_CLEAR: begin
            foreach (fb[i]) fb[i] = 8'h00;
            cur = '0;
         end
         gb_pkg::CMD_GLYPH: begin
            font_mem[it.addr] = it.byte_data;
            font_set[it.addr] = 1'b1;
         end
         gb_pkg::CMD_DESC: begin
            if (it.addr < gb_pkg::DESC_DEPTH) begin
               desc_w[it.addr]   = it.glyph_width;
               desc_off[it.addr] = it.glyph_offset;
               desc_set[it.addr] = 1'b1;
            end
         end
         gb_pkg::CMD_DRAW: render_char(it.char_code);
         gb_pkg::CMD_READ: if (it.addr < gb_pkg::FRAME_BYTES) o.read_byte = fb[it.addr];
         default: ;
      endcase
      o.cursor_pos = cur;
      return o;
   endfunction

   // one request transfer; returns after the accepting edge
   task automatic send_item(blit_cmd_type it, bit typed, blit_out_type want);
      int gap;
      blit_out_type o;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.cmd          = it.cmd;
      req_bus.addr         = it.addr;
      req_bus.byte_data    = it.byte_data;
      req_bus.glyph_width  = it.glyph_width;
      req_bus.glyph_offset = it.glyph_offset;
      req_bus.char_code    = it.char_code;
      do @(posedge clock); while (!req_bus.ready);
      o = blit_predict(it);
      pending_q.push_back(typed ? want : o);
   endtask

   task automatic send_cmd(blit_cmd_type it);
      blit_out_type none;
      none = '{default: '0};
      send_item(it, 1'b0, none);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         gb_pkg::REG_FIRST_CHAR:   cfg.first_char   = val;
         gb_pkg::REG_LAST_CHAR:    cfg.last_char    = val;
         gb_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height = val[5:0];
         gb_pkg::REG_CHAR_GAP:     cfg.char_gap     = val[3:0];
         gb_pkg::REG_LAYOUT:       cfg.layout       = val[0];
         gb_pkg::REG_LINE_STRIDE:  cfg.line_stride  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_config(logic [7:0] fc, logic [7:0] lc, logic [7:0] gh,
                             logic [7:0] gap, logic [7:0] lay, logic [7:0] stride);
      csr_write(gb_pkg::REG_FIRST_CHAR, fc);
      csr_write(gb_pkg::REG_LAST_CHAR, lc);
      csr_write(gb_pkg::REG_GLYPH_HEIGHT, gh);
      csr_write(gb_pkg::REG_CHAR_GAP, gap);
      csr_write(gb_pkg::REG_LAYOUT, lay);
      csr_write(gb_pkg::REG_LINE_STRIDE, stride);
   endtask

   function automatic blit_cmd_type mk(logic [2:0] c, int a, int d, int w, int off, int code);
      blit_cmd_type it;
      it.cmd = c;
      it.addr = 12'(a);
      it.byte_data = 8'(d);
      it.glyph_width = 6'(w);
      it.glyph_offset = 12'(off);
      it.char_code = 8'(code);
      return it;
   endfunction

   function automatic blit_cmd_type rand_item();
      int p, w;
      logic [7:0] code;
      p = $urandom_range(0, 99);
      if (p < 15) begin
         if ($urandom_range(0, 9) < 6)
            return mk(gb_pkg::CMD_GLYPH, $urandom_range(0, FONT_LO - 1), $urandom, 0, 0, 0);
         return mk(gb_pkg::CMD_GLYPH, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if (p < 27) begin
         p = $urandom_range(0, 19);
         w = (p < 14) ? $urandom_range(0, 16) : (p < 17) ? $urandom_range(17, 32)
                                                         : $urandom_range(33, 63);
         p = $urandom_range(0, 9);
         return mk(gb_pkg::CMD_DESC,
                   ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 4095),
                   $urandom, w,
                   (p < 8) ? $urandom_range(0, FONT_LO - 1) :
                   (p < 9) ? $urandom_range(FONT_HI, gb_pkg::GLYPH_BYTES - 1)
                           : $urandom_range(0, 4095),
                   $urandom);
      end
      if (p < 75) begin
         code = ($urandom_range(0, 3) != 0) ? 8'(cfg.first_char + $urandom_range(0, 15))
                                            : 8'($urandom);
         if (draw_ok(code))
            return mk(gb_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom, code);
         return mk(gb_pkg::CMD_READ, $urandom_range(0, gb_pkg::FRAME_BYTES - 1), 0, 0, 0, 0);
      end
      if (p < 94)
         return mk(gb_pkg::CMD_READ,
                   ($urandom_range(0, 9) < 7) ? $urandom_range(0, 255) : $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      if (p < 97)
         return mk(gb_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      return mk(3'($urandom_range(CMD_SPARE5, CMD_SPARE7)), $urandom, $urandom, $urandom,
                $urandom, $urandom);
   endfunction

   // result checker
   always @(posedge clock) begin
      blit_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_q.size() == 0) begin
            report("unexpected result", rsp_bus.cursor_pos, -1);
         end else begin
            want = pending_q.pop_front();
            if (rsp_bus.read_byte !== want.read_byte)
               report("read_byte", rsp_bus.read_byte, want.read_byte);
            if (rsp_bus.cursor_pos !== want.cursor_pos)
               report("cursor_pos", rsp_bus.cursor_pos, want.cursor_pos);
         end
      end
   end

   // result-side stalls
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_rsp) begin
            rsp_bus.ready = 1'b1;
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall = gap_len();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      blit_out_type zero;
      logic [7:0]   fc;

      req_bus.valid = 1'b0;
      req_bus.cmd = gb_pkg::CMD_READ;
      req_bus.addr = '0;
      req_bus.byte_data = '0;
      req_bus.glyph_width = '0;
      req_bus.glyph_offset = '0;
      req_bus.char_code = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = gb_pkg::REG_FIRST_CHAR;
      csr_bus.data = '0;

      foreach (fb[i]) fb[i] = 8'h00;
      foreach (font_set[i]) font_set[i] = 1'b0;
      foreach (desc_set[i]) desc_set[i] = 1'b0;
      cur = '0;
      cfg.first_char = 8'd32;
      cfg.last_char = 8'd126;
      cfg.glyph_height = 6'd8;
      cfg.char_gap = 4'd1;
      cfg.layout = 1'b0;
      cfg.line_stride = 8'd16;
      zero = '{default: '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // font bytes at the bottom and at the top of the glyph store
      for (int a = 0; a < FONT_LO; a++)
         send_cmd(mk(gb_pkg::CMD_GLYPH, a, $urandom, 0, 0, 0));
      for (int a = FONT_HI; a < gb_pkg::GLYPH_BYTES; a++)
         send_cmd(mk(gb_pkg::CMD_GLYPH, a, $urandom, 0, 0, 0));

      // directed table
      rows.push_back('{mk(gb_pkg::CMD_READ, 0, 0, 0, 0, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_READ, gb_pkg::FRAME_BYTES - 1, 255, 63, 4095, 255),
                       1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_READ, 4095, 0, 0, 0, 0), 1'b1, zero});
      rows.push_back('{mk(CMD_SPARE5, 4095, 255, 63, 4095, 255), 1'b1, zero});
      rows.push_back('{mk(CMD_SPARE7, 0, 0, 0, 0, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 0, 0, 8, 0, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 1, 0, 63, 0, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 2, 0, 0, 5, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 3, 0, 32, FONT_HI, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 4095, 0, 1, 1, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DESC, 255, 0, 5, 64, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 32), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 33), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 34), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 35), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 0), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 255), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_READ, 0, 0, 0, 0, 0), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_READ, 17, 0, 0, 0, 0), 1'b0, zero});
      rows.push_back('{mk(gb_pkg::CMD_CLEAR, 4095, 255, 63, 4095, 255), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_READ, 1, 0, 0, 0, 0), 1'b1, zero});
      rows.push_back('{mk(gb_pkg::CMD_DRAW, 0, 0, 0, 0, 33), 1'b0, zero});
      rows.push_back('{mk(CMD_SPARE6, 0, 0, 0, 0, 0), 1'b0, zero});
      foreach (rows[i]) begin
         row = rows[i];
         send_item(row.item, row.typed, row.out);
      end
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         quiet_rsp = (ph == 2);
         case (ph)
            0: set_config(8'd0, 8'd255, 8'd32, 8'd0, 8'd0, 8'd1);
            1: set_config(8'd255, 8'd0, 8'd63, 8'd15, 8'd1, 8'd255);
            2: set_config(8'd32, 8'd126, 8'd0, 8'd3, 8'd1, 8'd16);
            3: set_config(8'd40, 8'd200, 8'd12, 8'd2, 8'd0, 8'd0);
            4: set_config(8'd32, 8'd126, 8'd1, 8'd1, 8'd1, 8'd128);
            default: begin
               fc = 8'($urandom_range(0, 120));
               set_config(fc, 8'(fc + $urandom_range(0, 100)), 8'($urandom_range(1, 16)),
                          8'($urandom_range(0, 15)), 8'($urandom_range(0, 1)),
                          8'($urandom_range(1, 128)));
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(rand_item());
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
